### src/dsf_pkg.sv
// Shared package of the dual sensor fusion block: widths, codes, the queued item type,
// the configuration register set and the fusion function.
// Depends on nothing; every module of the block imports it.
package dsf_pkg;

	localparam int unsigned VAL_W             = 18;
	localparam int unsigned TEMP_W            = 15;
	localparam int unsigned HUMID_W           = 14;
	localparam int unsigned OFF_W             = 12;
	localparam int unsigned PERIOD_W          = 20;
	localparam int unsigned ERR_W             = 4;
	localparam int unsigned RETRY_W           = 2;
	localparam int unsigned CFG_IDX_W         = 3;
	localparam int unsigned CFG_DATA_W        = 20;
	localparam int unsigned IN_DATA_W         = 32;
	localparam int unsigned IN_USER_W         = 4;
	localparam int unsigned OUT_DATA_W        = 80;
	localparam int unsigned HISTORY_DEPTH_DEF = 5;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned DIV_STEPS         = 4;

	localparam logic [VAL_W-1:0]    NO_SENSOR_VALUE = 18'h279C4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 20'd60000;
	localparam logic [RETRY_W-1:0]  RETRY_LIMIT     = 2'd3;
	localparam logic [ERR_W-1:0]    ERROR_LIMIT     = 4'd10;

	localparam logic [1:0] CMD_READ = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_INIT = 2'd2;

	localparam logic [2:0] OP_NOP       = 3'd0;
	localparam logic [2:0] OP_READ_OK   = 3'd1;
	localparam logic [2:0] OP_READ_FAIL = 3'd2;
	localparam logic [2:0] OP_TICK      = 3'd3;
	localparam logic [2:0] OP_INIT      = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HUMID_OFF_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HUMID_OFF_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic               sel;
		logic               ok;
		logic [TEMP_W-1:0]  temp;
		logic [HUMID_W-1:0] humid;
	} item_t;

	typedef struct packed {
		logic [OFF_W-1:0]    temp_off_a;
		logic [OFF_W-1:0]    temp_off_b;
		logic [OFF_W-1:0]    humid_off_a;
		logic [OFF_W-1:0]    humid_off_b;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	// Floor mean of two working sensors, the single working one, or the no-sensor mark.
	function automatic logic [VAL_W-1:0] fuse(input logic w0, input logic w1,
			input logic [VAL_W-1:0] v0, input logic [VAL_W-1:0] v1);
		logic [VAL_W:0] s;
		begin
			s = {v0[VAL_W-1], v0} + {v1[VAL_W-1], v1};
			if (w0 && w1) begin
				fuse = s[VAL_W:1];
			end else if (w0) begin
				fuse = v0;
			end else if (w1) begin
				fuse = v1;
			end else begin
				fuse = NO_SENSOR_VALUE;
			end
		end
	endfunction

endpackage

### src/dsf_front.sv
// Front part: accepts input transactions, classifies them into operations and holds
// the configuration registers. Depends on dsf_pkg.
module dsf_front import dsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  q_push,
	output item_t                 q_item,
	output cfg_t                  cfg
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_new;
	cfg_t  cfg_q;
	logic  accept;

	assign s_axis_tready = !valid_s1 || !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = valid_s1 && !q_full;
	assign q_item        = item_s1;
	assign cfg_ready     = 1'b1;
	assign cfg           = cfg_q;

	always_comb begin
		item_new.sel   = s_axis_tuser[2];
		item_new.ok    = s_axis_tuser[3];
		item_new.temp  = s_axis_tdata[TEMP_W-1:0];
		item_new.humid = s_axis_tdata[TEMP_W+HUMID_W-1:TEMP_W];
		case (s_axis_tuser[1:0])
			CMD_READ: begin
				item_new.op = s_axis_tuser[3] ? OP_READ_OK : OP_READ_FAIL;
			end
			CMD_TICK: begin
				item_new.op = OP_TICK;
			end
			CMD_INIT: begin
				item_new.op = OP_INIT;
			end
			default: begin
				item_new.op = OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_off_a  <= '0;
			cfg_q.temp_off_b  <= '0;
			cfg_q.humid_off_a <= '0;
			cfg_q.humid_off_b <= '0;
			cfg_q.period      <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TEMP_OFF_A: begin
					cfg_q.temp_off_a <= cfg_data[OFF_W-1:0];
				end
				CFG_TEMP_OFF_B: begin
					cfg_q.temp_off_b <= cfg_data[OFF_W-1:0];
				end
				CFG_HUMID_OFF_A: begin
					cfg_q.humid_off_a <= cfg_data[OFF_W-1:0];
				end
				CFG_HUMID_OFF_B: begin
					cfg_q.humid_off_b <= cfg_data[OFF_W-1:0];
				end
				CFG_PERIOD: begin
					cfg_q.period <= cfg_data[PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### src/dsf_queue.sv
// Short first-in first-out queue of classified items between the front and back parts.
// Depends on dsf_pkg for the item type and depth.
module dsf_queue import dsf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head_item,
	output logic  full,
	output logic  empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/dsf_div.sv
// Sequential signed floor divider of a history sum by a small slot count,
// several quotient bits per cycle. Depends on dsf_pkg.
module dsf_div import dsf_pkg::*; #(
	parameter int unsigned SUM_W = 21,
	parameter int unsigned CNT_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [VAL_W-1:0] quot
);

	localparam int unsigned DIV_W  = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int unsigned ROUNDS = DIV_W / DIV_STEPS;
	localparam int unsigned RND_W  = $clog2(ROUNDS + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dvd_nx;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W:0]   rem_nx;
	logic [CNT_W-1:0] dvs_q;
	logic             neg_q;
	logic [RND_W-1:0] rnd_q;
	logic             busy_q;
	logic             done_q;
	logic [SUM_W-1:0] mag;
	logic [VAL_W-1:0] q_adj;

	assign mag = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;

	always_comb begin
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			rem_nx = {rem_nx[CNT_W-1:0], dvd_nx[DIV_W-1]};
			dvd_nx = {dvd_nx[DIV_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, dvs_q}) begin
				rem_nx    = rem_nx - {1'b0, dvs_q};
				dvd_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			rnd_q  <= RND_W'(ROUNDS);
		end else if (busy_q) begin
			rnd_q <= rnd_q - RND_W'(1);
			if (rnd_q == RND_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DIV_W'(mag);
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= sum[SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
		end
	end

	// A negative sum with a remainder rounds one further down.
	assign q_adj = dvd_q[VAL_W-1:0] + VAL_W'(rem_q != '0);
	assign quot  = neg_q ? (~q_adj + VAL_W'(1)) : dvd_q[VAL_W-1:0];
	assign done  = done_q;

endmodule

### src/dsf_back.sv
// Back part: carries out queued operations on the sensor state, keeps the history ring,
// walks it for the averages and drives the result register. Depends on dsf_pkg, dsf_div.
module dsf_back import dsf_pkg::*; #(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 q_item,
	input  logic                  q_empty,
	output logic                  q_pop,
	input  cfg_t                  cfg,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SUM_W = VAL_W + CNT_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_START = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	logic [1:0]          state_q;
	logic [VAL_W-1:0]    last_t_q [2];
	logic [VAL_W-1:0]    last_h_q [2];
	logic [1:0]          work_q;
	logic [RETRY_W-1:0]  rcnt_q [2];
	logic [ERR_W-1:0]    err_q;
	logic [PERIOD_W-1:0] tick_q;
	logic [VAL_W-1:0]    tring_q [HISTORY_DEPTH];
	logic [VAL_W-1:0]    hring_q [HISTORY_DEPTH];
	logic [IDX_W-1:0]    ring_idx_q;
	logic                retry_req_q;
	logic                restart_req_q;
	logic [IDX_W-1:0]    walk_q;
	logic [SUM_W-1:0]    tsum_q;
	logic [SUM_W-1:0]    hsum_q;
	logic [CNT_W-1:0]    tcnt_q;
	logic [CNT_W-1:0]    hcnt_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                sel;
	logic [OFF_W-1:0]    toff;
	logic [OFF_W-1:0]    hoff;
	logic [VAL_W-1:0]    new_t;
	logic [VAL_W-1:0]    new_h;
	logic [RETRY_W-1:0]  rc_inc;
	logic [ERR_W-1:0]    ec_inc;
	logic [PERIOD_W-1:0] tick_inc;
	logic [VAL_W-1:0]    fuse_t;
	logic [VAL_W-1:0]    fuse_h;
	logic [VAL_W-1:0]    slot_t;
	logic [VAL_W-1:0]    slot_h;
	logic                div_start;
	logic                tdone;
	logic                hdone;
	logic [VAL_W-1:0]    tquot;
	logic [VAL_W-1:0]    hquot;
	logic [VAL_W-1:0]    avg_t;
	logic [VAL_W-1:0]    avg_h;
	logic                load;

	assign sel      = q_item.sel;
	assign toff     = sel ? cfg.temp_off_b : cfg.temp_off_a;
	assign hoff     = sel ? cfg.humid_off_b : cfg.humid_off_a;
	assign new_t    = {{(VAL_W-TEMP_W){q_item.temp[TEMP_W-1]}}, q_item.temp}
		+ {{(VAL_W-OFF_W){toff[OFF_W-1]}}, toff};
	assign new_h    = {{(VAL_W-HUMID_W){1'b0}}, q_item.humid}
		+ {{(VAL_W-OFF_W){hoff[OFF_W-1]}}, hoff};
	assign rc_inc   = rcnt_q[sel] + RETRY_W'(1);
	assign ec_inc   = err_q + ERR_W'(1);
	assign tick_inc = tick_q + PERIOD_W'(1);
	assign fuse_t   = fuse(work_q[0], work_q[1], last_t_q[0], last_t_q[1]);
	assign fuse_h   = fuse(work_q[0], work_q[1], last_h_q[0], last_h_q[1]);
	assign slot_t   = tring_q[walk_q];
	assign slot_h   = hring_q[walk_q];

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign div_start = (state_q == ST_START);
	assign load      = (state_q == ST_DIV) && tdone && hdone
		&& (!out_valid_q || m_axis_tready);
	assign avg_t     = (tcnt_q == '0) ? fuse_t : tquot;
	assign avg_h     = (hcnt_q == '0) ? fuse_h : hquot;

	dsf_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_t (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sum     (tsum_q),
		.divisor (tcnt_q),
		.done    (tdone),
		.quot    (tquot)
	);

	dsf_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_h (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sum     (hsum_q),
		.divisor (hcnt_q),
		.done    (hdone),
		.quot    (hquot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			last_t_q[0]   <= '0;
			last_t_q[1]   <= '0;
			last_h_q[0]   <= '0;
			last_h_q[1]   <= '0;
			work_q        <= '0;
			rcnt_q[0]     <= '0;
			rcnt_q[1]     <= '0;
			err_q         <= '0;
			tick_q        <= '0;
			ring_idx_q    <= '0;
			retry_req_q   <= 1'b0;
			restart_req_q <= 1'b0;
			walk_q        <= '0;
			tsum_q        <= '0;
			hsum_q        <= '0;
			tcnt_q        <= '0;
			hcnt_q        <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				tring_q[i] <= '0;
				hring_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						retry_req_q   <= 1'b0;
						restart_req_q <= 1'b0;
						walk_q        <= '0;
						tsum_q        <= '0;
						hsum_q        <= '0;
						tcnt_q        <= '0;
						hcnt_q        <= '0;
						state_q       <= ST_WALK;
						case (q_item.op)
							OP_READ_OK: begin
								if (work_q[sel]) begin
									last_t_q[sel] <= new_t;
									last_h_q[sel] <= new_h;
									err_q         <= '0;
									rcnt_q[sel]   <= '0;
								end
							end
							OP_READ_FAIL: begin
								if (work_q[sel]) begin
									if (rc_inc >= RETRY_LIMIT) begin
										work_q[sel] <= 1'b0;
										rcnt_q[sel] <= '0;
									end else begin
										rcnt_q[sel] <= rc_inc;
										retry_req_q <= 1'b1;
									end
									if (ec_inc > ERROR_LIMIT) begin
										err_q         <= '0;
										restart_req_q <= 1'b1;
									end else begin
										err_q <= ec_inc;
									end
								end
							end
							OP_INIT: begin
								work_q[sel] <= q_item.ok;
								rcnt_q[sel] <= '0;
							end
							OP_TICK: begin
								if (tick_inc >= cfg.period) begin
									tick_q              <= '0;
									tring_q[ring_idx_q] <= fuse_t;
									hring_q[ring_idx_q] <= fuse_h;
									ring_idx_q <= (ring_idx_q == IDX_LAST) ? '0
										: ring_idx_q + IDX_W'(1);
								end else begin
									tick_q <= tick_inc;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (slot_t != '0) begin
						tsum_q <= tsum_q + {{CNT_W{slot_t[VAL_W-1]}}, slot_t};
						tcnt_q <= tcnt_q + CNT_W'(1);
					end
					if (slot_h != '0) begin
						hsum_q <= hsum_q + {{CNT_W{slot_h[VAL_W-1]}}, slot_h};
						hcnt_q <= hcnt_q + CNT_W'(1);
					end
					if (walk_q == IDX_LAST) begin
						state_q <= ST_START;
					end else begin
						walk_q <= walk_q + IDX_W'(1);
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {restart_req_q, retry_req_q, err_q, work_q[1], work_q[0],
				avg_h, avg_t, fuse_h, fuse_t};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### src/dual_sensor_fusion_with_history.sv
// Path: an accepted transaction is registered in the front part, waits in the queue and is
// taken by the back part, which walks the history ring, starts both dividers and loads the
// result register once they are done and the output is free. The back part takes a new
// transaction only after that load; the front part and the queue can hold further ones.
// Reset: arst_n clears all sensor state, the history ring, the queue and the configuration
// registers at once; the history period returns to 60000 ticks.
module dual_sensor_fusion_with_history import dsf_pkg::*; #(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// temp_sample [14:0], humid_sample [28:15], zero [31:29]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd [1:0], sensor_sel [2], read_ok [3]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// fused_temp [17:0], fused_humid [35:18], avg_temp [53:36], avg_humid [71:54],
	// sensor_a_ok [72], sensor_b_ok [73], error_total [77:74], retry_request [78],
	// restart_request [79]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	item_t push_item;
	item_t head_item;
	cfg_t  cfg;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	dsf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_full        (full),
		.q_push        (push),
		.q_item        (push_item),
		.cfg           (cfg)
	);

	dsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (full),
		.empty     (empty)
	);

	dsf_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (head_item),
		.q_empty       (empty),
		.q_pop         (pop),
		.cfg           (cfg),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### src/dsf_checker.sv
// Port-level checker of the dual sensor fusion block, bound to its top level.
// Depends on dsf_pkg and on dual_sensor_fusion_with_history.
module dsf_checker import dsf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// A stalled result transaction keeps its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	else $error("result changed while stalled");

	// The consecutive error count never shows more than ten.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[77:74] <= ERROR_LIMIT)
	else $error("error total above limit");

	// A restart request always comes with a cleared error count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[79] |-> m_axis_tdata[77:74] == '0)
	else $error("restart without cleared error total");

	// The no-sensor mark appears exactly when neither sensor works.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[72] || m_axis_tdata[73])
			== ((m_axis_tdata[17:0] != NO_SENSOR_VALUE)
			&& (m_axis_tdata[35:18] != NO_SENSOR_VALUE))))
	else $error("fused value disagrees with working flags");

endmodule

bind dual_sensor_fusion_with_history dsf_checker u_dsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
